// ===== sv/mcom_pkg.sv =====
// shared types, constants and helpers for the mesh center of mass unit
package mcom_pkg;

    localparam int MAX_TRIANGLES = 4096;
    localparam int COORD_BITS    = 12;
    localparam int CW            = 12;
    localparam int PW            = 2 * CW;
    localparam int DW            = PW + 1;
    localparam int TW            = CW + DW;
    localparam int VW            = TW + 2;
    localparam int SW            = CW + 2;
    localparam int MW            = SW + VW;
    localparam int ACC_W         = 64;
    localparam int CEN_W         = 20;
    localparam int SIXV_W        = 63;
    localparam int CNT_W         = $clog2(MAX_TRIANGLES + 1);
    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);
    localparam int FRONT_STAGES  = 4;
    localparam int OCC_W         = $clog2(FIFO_DEPTH + FRONT_STAGES + 1);
    localparam int NUM_AXES      = 3;
    localparam int INT_SHIFT     = 14;
    localparam int QW            = INT_SHIFT + 1;
    localparam int FW            = 8;
    localparam int FRAC_SHIFT    = 7;
    localparam int DSH_W         = ACC_W + INT_SHIFT;
    localparam int STEP_W        = 4;
    localparam int MAG_W         = 22;

    typedef struct packed {
        logic signed [VW-1:0] v;
        logic signed [MW-1:0] mx;
        logic signed [MW-1:0] my;
        logic signed [MW-1:0] mz;
        logic                 last;
    } t_tri;

    typedef enum logic [1:0] {
        BK_ACC,
        BK_START,
        BK_WAIT,
        BK_OUT
    } t_back_state;

    typedef enum logic [2:0] {
        DV_IDLE,
        DV_INT,
        DV_FSET,
        DV_FRAC,
        DV_DONE
    } t_div_state;

    function automatic logic signed [CW-1:0] coord_of(input logic [CW-1:0] raw);
        logic [CW-1:0] m;
        m = raw;
        for (int i = COORD_BITS; i < CW; i++) begin
            m[i] = raw[COORD_BITS-1];
        end
        return signed'(m);
    endfunction

endpackage

// ===== sv/mcom_fifo.sv =====
// short queue of per-triangle products between front and back
module mcom_fifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  mcom_pkg::t_tri                i_entry,
    input  logic                          i_pop,
    output mcom_pkg::t_tri                o_head,
    output logic                          o_empty,
    output logic [mcom_pkg::FIFO_CW-1:0]  o_count
);
    mcom_pkg::t_tri                 r_mem [mcom_pkg::FIFO_DEPTH];
    logic [mcom_pkg::FIFO_AW-1:0]   r_wr;
    logic [mcom_pkg::FIFO_AW-1:0]   r_rd;
    logic [mcom_pkg::FIFO_CW-1:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (!i_push && i_pop) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    assign o_head  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
endmodule

// ===== sv/mcom_front.sv =====
// front pipeline: triple product and moment products per triangle
module mcom_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [11:0]                   i_ax,
    input  logic [11:0]                   i_ay,
    input  logic [11:0]                   i_az,
    input  logic [11:0]                   i_bx,
    input  logic [11:0]                   i_by_coord,
    input  logic [11:0]                   i_bz,
    input  logic [11:0]                   i_cx,
    input  logic [11:0]                   i_cy,
    input  logic [11:0]                   i_cz,
    input  logic                          i_last_triangle,
    input  logic [mcom_pkg::FIFO_CW-1:0]  i_fifo_count,
    output logic                          o_stall,
    output logic                          o_push,
    output mcom_pkg::t_tri                o_entry
);
    logic [mcom_pkg::FRONT_STAGES-1:0] r_vld;
    logic [mcom_pkg::FRONT_STAGES-1:0] r_last;
    logic [mcom_pkg::OCC_W-1:0]        occ;
    logic                              take;

    logic signed [mcom_pkg::CW-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;

    logic signed [mcom_pkg::PW-1:0] r_p0, r_p1, r_p2, r_p3, r_p4, r_p5;
    logic signed [mcom_pkg::CW-1:0] r_ax, r_ay, r_az;
    logic signed [mcom_pkg::SW-1:0] r_s1x, r_s1y, r_s1z;
    logic signed [mcom_pkg::TW-1:0] r_t0, r_t1, r_t2;
    logic signed [mcom_pkg::SW-1:0] r_s2x, r_s2y, r_s2z;
    logic signed [mcom_pkg::VW-1:0] r_v3;
    logic signed [mcom_pkg::SW-1:0] r_s3x, r_s3y, r_s3z;
    logic signed [mcom_pkg::VW-1:0] r_v4;
    logic signed [mcom_pkg::MW-1:0] r_mx, r_my, r_mz;

    assign occ = mcom_pkg::OCC_W'(i_fifo_count) + mcom_pkg::OCC_W'($countones(r_vld));
    assign o_stall = (occ >= mcom_pkg::OCC_W'(mcom_pkg::FIFO_DEPTH));
    assign take = i_valid && !o_stall;

    assign ax = mcom_pkg::coord_of(i_ax);
    assign ay = mcom_pkg::coord_of(i_ay);
    assign az = mcom_pkg::coord_of(i_az);
    assign bx = mcom_pkg::coord_of(i_bx);
    assign by = mcom_pkg::coord_of(i_by_coord);
    assign bz = mcom_pkg::coord_of(i_bz);
    assign cx = mcom_pkg::coord_of(i_cx);
    assign cy = mcom_pkg::coord_of(i_cy);
    assign cz = mcom_pkg::coord_of(i_cz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[mcom_pkg::FRONT_STAGES-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= {r_last[mcom_pkg::FRONT_STAGES-2:0], i_last_triangle};
        // stage 1: cross product terms
        r_p0  <= by * cz;
        r_p1  <= bz * cy;
        r_p2  <= bz * cx;
        r_p3  <= bx * cz;
        r_p4  <= bx * cy;
        r_p5  <= by * cx;
        r_ax  <= ax;
        r_ay  <= ay;
        r_az  <= az;
        r_s1x <= mcom_pkg::SW'(ax) + mcom_pkg::SW'(bx) + mcom_pkg::SW'(cx);
        r_s1y <= mcom_pkg::SW'(ay) + mcom_pkg::SW'(by) + mcom_pkg::SW'(cy);
        r_s1z <= mcom_pkg::SW'(az) + mcom_pkg::SW'(bz) + mcom_pkg::SW'(cz);
        // stage 2: dot product terms
        r_t0  <= r_ax * (mcom_pkg::DW'(r_p0) - mcom_pkg::DW'(r_p1));
        r_t1  <= r_ay * (mcom_pkg::DW'(r_p2) - mcom_pkg::DW'(r_p3));
        r_t2  <= r_az * (mcom_pkg::DW'(r_p4) - mcom_pkg::DW'(r_p5));
        r_s2x <= r_s1x;
        r_s2y <= r_s1y;
        r_s2z <= r_s1z;
        // stage 3: triple product
        r_v3  <= mcom_pkg::VW'(r_t0) + mcom_pkg::VW'(r_t1) + mcom_pkg::VW'(r_t2);
        r_s3x <= r_s2x;
        r_s3y <= r_s2y;
        r_s3z <= r_s2z;
        // stage 4: moment products
        r_mx  <= r_s3x * r_v3;
        r_my  <= r_s3y * r_v3;
        r_mz  <= r_s3z * r_v3;
        r_v4  <= r_v3;
    end

    assign o_push        = r_vld[mcom_pkg::FRONT_STAGES-1];
    assign o_entry.v     = r_v4;
    assign o_entry.mx    = r_mx;
    assign o_entry.my    = r_my;
    assign o_entry.mz    = r_mz;
    assign o_entry.last  = r_last[mcom_pkg::FRONT_STAGES-1];
endmodule

// ===== sv/mcom_div.sv =====
// serial divider: rounded, saturated Q12.8 quotient moment / (4 * volume)
module mcom_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic [mcom_pkg::ACC_W-1:0]           i_mom,
    input  logic [mcom_pkg::ACC_W-1:0]           i_vol,
    output logic                                 o_done,
    output logic [mcom_pkg::CEN_W-1:0]           o_center
);
    mcom_pkg::t_div_state              r_state, n_state;
    logic [mcom_pkg::ACC_W-1:0]        r_rem;
    logic [mcom_pkg::DSH_W-1:0]        r_dsh;
    logic [mcom_pkg::ACC_W-1:0]        r_vm;
    logic [mcom_pkg::QW-1:0]           r_q;
    logic [mcom_pkg::FW-1:0]           r_f;
    logic [mcom_pkg::STEP_W-1:0]       r_cnt;
    logic                              r_neg;
    logic [mcom_pkg::ACC_W-1:0]        mm, vm, dsm;
    logic                              ge, vm_low;
    logic [mcom_pkg::FRAC_SHIFT-1:0]   fq;
    logic [mcom_pkg::MAG_W-1:0]        mag;

    localparam logic [mcom_pkg::ACC_W-1:0] SMALL_LIM = mcom_pkg::ACC_W'(1) << 56;
    localparam logic [mcom_pkg::MAG_W-1:0] CenMax    = mcom_pkg::MAG_W'(524287);
    localparam logic [mcom_pkg::MAG_W-1:0] CenMinMag = mcom_pkg::MAG_W'(524288);

    assign mm     = i_mom[mcom_pkg::ACC_W-1] ? (~i_mom + 1'b1) : i_mom;
    assign vm     = i_vol[mcom_pkg::ACC_W-1] ? (~i_vol + 1'b1) : i_vol;
    assign ge     = ({{mcom_pkg::INT_SHIFT{1'b0}}, r_rem} >= r_dsh);
    assign vm_low = (r_vm <= SMALL_LIM);
    assign dsm    = vm_low ? r_vm : (r_vm >> mcom_pkg::FRAC_SHIFT);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcom_pkg::DV_IDLE: if (i_start) n_state = mcom_pkg::DV_INT;
            mcom_pkg::DV_INT:  if (r_cnt == '0) n_state = mcom_pkg::DV_FSET;
            mcom_pkg::DV_FSET: n_state = mcom_pkg::DV_FRAC;
            mcom_pkg::DV_FRAC: if (r_cnt == '0) n_state = mcom_pkg::DV_DONE;
            mcom_pkg::DV_DONE: n_state = mcom_pkg::DV_IDLE;
            default:           n_state = mcom_pkg::DV_IDLE;
        endcase
    end

    always_comb begin
        fq  = (r_f > mcom_pkg::FW'(127)) ? mcom_pkg::FRAC_SHIFT'(127)
                                         : r_f[mcom_pkg::FRAC_SHIFT-1:0];
        mag = (mcom_pkg::MAG_W'({r_q[mcom_pkg::QW-2:0], fq}) + 1'b1) >> 1;
        if (r_q[mcom_pkg::QW-1]) mag = CenMinMag + 1'b1;
        if (r_neg) begin
            if (mag > CenMinMag) mag = CenMinMag;
            mag = ~mag + 1'b1;
        end else if (mag > CenMax) begin
            mag = CenMax;
        end
        o_center = mag[mcom_pkg::CEN_W-1:0];
        o_done   = (r_state == mcom_pkg::DV_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mcom_pkg::DV_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            mcom_pkg::DV_IDLE: begin
                r_rem <= mm;
                r_dsh <= {vm, {mcom_pkg::INT_SHIFT{1'b0}}};
                r_vm  <= vm;
                r_neg <= i_mom[mcom_pkg::ACC_W-1] ^ i_vol[mcom_pkg::ACC_W-1];
                r_q   <= '0;
                r_cnt <= mcom_pkg::STEP_W'(mcom_pkg::INT_SHIFT);
            end
            mcom_pkg::DV_INT: begin
                if (ge) r_rem <= r_rem - r_dsh[mcom_pkg::ACC_W-1:0];
                r_q   <= {r_q[mcom_pkg::QW-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            mcom_pkg::DV_FSET: begin
                r_rem <= vm_low ? (r_rem << mcom_pkg::FRAC_SHIFT) : r_rem;
                r_dsh <= {{(mcom_pkg::INT_SHIFT - mcom_pkg::FRAC_SHIFT){1'b0}},
                          dsm, {mcom_pkg::FRAC_SHIFT{1'b0}}};
                r_f   <= '0;
                r_cnt <= mcom_pkg::STEP_W'(mcom_pkg::FW - 1);
            end
            mcom_pkg::DV_FRAC: begin
                if (ge) r_rem <= r_rem - r_dsh[mcom_pkg::ACC_W-1:0];
                r_f   <= {r_f[mcom_pkg::FW-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 1'b1;
            end
            mcom_pkg::DV_DONE: begin
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== sv/mcom_back.sv =====
// back end: accumulators, per-axis division sequencing and result register
module mcom_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mcom_pkg::t_tri                i_head,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [19:0]                   o_center_x,
    output logic [19:0]                   o_center_y,
    output logic [19:0]                   o_center_z,
    output logic [62:0]                   o_six_volume,
    output logic                          o_degenerate,
    output logic                          o_overflow
);
    mcom_pkg::t_back_state           r_state, n_state;
    logic [mcom_pkg::ACC_W-1:0]      r_mx, r_my, r_mz, r_vol;
    logic [mcom_pkg::ACC_W-1:0]      n_mx, n_my, n_mz, n_vol;
    logic [mcom_pkg::CNT_W-1:0]      r_cnt;
    logic                            r_exc;
    logic                            r_degen;
    logic [1:0]                      r_axis;
    logic [mcom_pkg::CEN_W-1:0]      r_cen [mcom_pkg::NUM_AXES];
    logic [mcom_pkg::ACC_W-1:0]      div_mom;
    logic                            div_start, div_done;
    logic [mcom_pkg::CEN_W-1:0]      div_center;
    logic                            out_free, load, last_axis;
    logic                            r_o_valid;

    assign n_mx  = r_mx  + {{(mcom_pkg::ACC_W-mcom_pkg::MW){i_head.mx[mcom_pkg::MW-1]}}, i_head.mx};
    assign n_my  = r_my  + {{(mcom_pkg::ACC_W-mcom_pkg::MW){i_head.my[mcom_pkg::MW-1]}}, i_head.my};
    assign n_mz  = r_mz  + {{(mcom_pkg::ACC_W-mcom_pkg::MW){i_head.mz[mcom_pkg::MW-1]}}, i_head.mz};
    assign n_vol = r_vol + {{(mcom_pkg::ACC_W-mcom_pkg::VW){i_head.v[mcom_pkg::VW-1]}}, i_head.v};
    assign out_free  = !r_o_valid || !i_stall;
    assign last_axis = (r_axis == 2'(mcom_pkg::NUM_AXES - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mcom_pkg::BK_ACC: begin
                if (!i_empty && i_head.last)
                    n_state = (n_vol == '0) ? mcom_pkg::BK_OUT : mcom_pkg::BK_START;
            end
            mcom_pkg::BK_START: n_state = mcom_pkg::BK_WAIT;
            mcom_pkg::BK_WAIT: begin
                if (div_done) n_state = last_axis ? mcom_pkg::BK_OUT : mcom_pkg::BK_START;
            end
            mcom_pkg::BK_OUT: if (out_free) n_state = mcom_pkg::BK_ACC;
            default: n_state = mcom_pkg::BK_ACC;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == mcom_pkg::BK_ACC) && !i_empty;
        div_start = (r_state == mcom_pkg::BK_START);
        load      = (r_state == mcom_pkg::BK_OUT) && out_free;
        unique case (r_axis)
            2'd0:    div_mom = r_mx;
            2'd1:    div_mom = r_my;
            default: div_mom = r_mz;
        endcase
    end

    mcom_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_mom    (div_mom),
        .i_vol    (r_vol),
        .o_done   (div_done),
        .o_center (div_center)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mcom_pkg::BK_ACC;
            r_mx      <= '0;
            r_my      <= '0;
            r_mz      <= '0;
            r_vol     <= '0;
            r_cnt     <= '0;
            r_exc     <= 1'b0;
            r_o_valid <= 1'b0;
            r_axis    <= '0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_mx  <= '0;
                r_my  <= '0;
                r_mz  <= '0;
                r_vol <= '0;
                r_cnt <= '0;
                r_exc <= 1'b0;
            end else if (o_pop) begin
                r_mx  <= n_mx;
                r_my  <= n_my;
                r_mz  <= n_mz;
                r_vol <= n_vol;
                if (r_cnt >= mcom_pkg::CNT_W'(mcom_pkg::MAX_TRIANGLES)) r_exc <= 1'b1;
                else                                                     r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == mcom_pkg::BK_ACC)   r_axis <= '0;
            else if (div_done && !last_axis)   r_axis <= r_axis + 1'b1;
            if (load)               r_o_valid <= 1'b1;
            else if (!i_stall)      r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) r_degen <= (n_vol == '0);
        if (div_done) r_cen[r_axis] <= div_center;
        if (load) begin
            o_center_x   <= r_degen ? '0 : r_cen[0];
            o_center_y   <= r_degen ? '0 : r_cen[1];
            o_center_z   <= r_degen ? '0 : r_cen[2];
            o_six_volume <= r_vol[mcom_pkg::SIXV_W-1:0];
            o_degenerate <= r_degen;
            o_overflow   <= r_exc;
        end
    end

    assign o_valid = r_o_valid;
endmodule

// ===== sv/mesh_center_of_mass_unit.sv =====
// top level of the mesh center of mass unit
// throughput: one triangle per cycle while the queue has room
// the front pipeline feeds the queue; after the last triangle leaves the queue, the back
//   runs three serial divisions to the result, one per axis, of 23 steps each
// a degenerate mesh skips the division; the front keeps filling the queue meanwhile
// synchronous active-low reset clears all sums, counters, queue and valid flags
module mesh_center_of_mass_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [11:0] i_ax,
    input  logic [11:0] i_ay,
    input  logic [11:0] i_az,
    input  logic [11:0] i_bx,
    input  logic [11:0] i_by_coord,
    input  logic [11:0] i_bz,
    input  logic [11:0] i_cx,
    input  logic [11:0] i_cy,
    input  logic [11:0] i_cz,
    input  logic        i_last_triangle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [19:0] o_center_x,
    output logic [19:0] o_center_y,
    output logic [19:0] o_center_z,
    output logic [62:0] o_six_volume,
    output logic        o_degenerate,
    output logic        o_overflow
);
    logic                          push, pop, empty;
    mcom_pkg::t_tri                entry, head;
    logic [mcom_pkg::FIFO_CW-1:0]  count;

    mcom_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_ax            (i_ax),
        .i_ay            (i_ay),
        .i_az            (i_az),
        .i_bx            (i_bx),
        .i_by_coord      (i_by_coord),
        .i_bz            (i_bz),
        .i_cx            (i_cx),
        .i_cy            (i_cy),
        .i_cz            (i_cz),
        .i_last_triangle (i_last_triangle),
        .i_fifo_count    (count),
        .o_stall         (o_stall),
        .o_push          (push),
        .o_entry         (entry)
    );

    mcom_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_count (count)
    );

    mcom_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_empty      (empty),
        .o_pop        (pop),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_center_x   (o_center_x),
        .o_center_y   (o_center_y),
        .o_center_z   (o_center_z),
        .o_six_volume (o_six_volume),
        .o_degenerate (o_degenerate),
        .o_overflow   (o_overflow)
    );
endmodule

// ===== sv/mcom_checker.sv =====
// port-level checker for the mesh center of mass unit, bound to the top level
module mcom_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [19:0] o_center_x,
    input logic [19:0] o_center_y,
    input logic [19:0] o_center_z,
    input logic [62:0] o_six_volume,
    input logic        o_degenerate
);
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_six_volume) && $stable(o_center_x))
        else $error("stalled result changed");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |->
            o_center_x == '0 && o_center_y == '0 && o_center_z == '0
            && o_six_volume == '0)
        else $error("degenerate result with nonzero fields");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind mesh_center_of_mass_unit mcom_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_center_x   (o_center_x),
    .o_center_y   (o_center_y),
    .o_center_z   (o_center_z),
    .o_six_volume (o_six_volume),
    .o_degenerate (o_degenerate)
);

// ===== tb/mesh_center_of_mass_checker.sv =====
// checker for the mesh center of mass unit: predicts each mesh result and compares
module mesh_center_of_mass_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [11:0] i_ax,
    input  logic [11:0] i_ay,
    input  logic [11:0] i_az,
    input  logic [11:0] i_bx,
    input  logic [11:0] i_by_coord,
    input  logic [11:0] i_bz,
    input  logic [11:0] i_cx,
    input  logic [11:0] i_cy,
    input  logic [11:0] i_cz,
    input  logic        i_last_triangle,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [19:0] i_center_x,
    input  logic [19:0] i_center_y,
    input  logic [19:0] i_center_z,
    input  logic [62:0] i_six_volume,
    input  logic        i_degenerate,
    input  logic        i_overflow,
    output int          o_failures,
    output int          o_backlog
);
    typedef struct packed {
        logic [19:0] cx;
        logic [19:0] cy;
        logic [19:0] cz;
        logic [62:0] sixv;
        logic        degen;
        logic        ovf;
    } t_mesh_result;

    t_mesh_result mesh_results_q[$];
    logic [63:0]  mom_x, mom_y, mom_z, vol_acc;
    int           tri_cnt;
    logic         cnt_over;

    initial begin
        o_failures = 0;
        o_backlog  = 0;
        mom_x = '0;
        mom_y = '0;
        mom_z = '0;
        vol_acc = '0;
        tri_cnt = 0;
        cnt_over = 1'b0;
    end

    function automatic logic [19:0] center_q12_8(input logic [63:0] mom, input logic [63:0] vol);
        logic        neg;
        logic [63:0] mm, vm, q, r, t, d, mag;
        neg = mom[63] ^ vol[63];
        mm  = mom[63] ? -mom : mom;
        vm  = vol[63] ? -vol : vol;
        q   = mm / vm;
        r   = mm % vm;
        if (q >= 64'd16384) begin
            mag = 64'd524289;
        end else begin
            t = q * 64'd128;
            if (vm <= (64'd1 << 56)) begin
                t = t + (r * 64'd128) / vm;
            end else begin
                d = r / (vm >> 7);
                t = t + ((d > 64'd127) ? 64'd127 : d);
            end
            mag = (t + 64'd1) >> 1;
        end
        if (neg) begin
            if (mag > 64'd524288) mag = 64'd524288;
            mag = -mag;
        end else if (mag > 64'd524287) begin
            mag = 64'd524287;
        end
        return mag[19:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        o_failures++;
    endtask

    // triangle transfer: accumulate and, on the last one, form the expected result
    always @(posedge i_clk) begin
        longint       ax, ay, az, bx, by, bz, cx, cy, cz, v;
        t_mesh_result res;
        if (i_rst_n && i_valid && !i_stall_in) begin
            ax = longint'($signed(i_ax));
            ay = longint'($signed(i_ay));
            az = longint'($signed(i_az));
            bx = longint'($signed(i_bx));
            by = longint'($signed(i_by_coord));
            bz = longint'($signed(i_bz));
            cx = longint'($signed(i_cx));
            cy = longint'($signed(i_cy));
            cz = longint'($signed(i_cz));
            v = ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz) + az * (bx * cy - by * cx);
            mom_x   = mom_x + 64'((ax + bx + cx) * v);
            mom_y   = mom_y + 64'((ay + by + cy) * v);
            mom_z   = mom_z + 64'((az + bz + cz) * v);
            vol_acc = vol_acc + 64'(v);
            if (tri_cnt >= mcom_pkg::MAX_TRIANGLES) cnt_over = 1'b1;
            else tri_cnt++;
            if (i_last_triangle) begin
                if (vol_acc == '0) begin
                    res.cx = '0;
                    res.cy = '0;
                    res.cz = '0;
                    res.degen = 1'b1;
                end else begin
                    res.cx = center_q12_8(mom_x, vol_acc);
                    res.cy = center_q12_8(mom_y, vol_acc);
                    res.cz = center_q12_8(mom_z, vol_acc);
                    res.degen = 1'b0;
                end
                res.sixv = vol_acc[62:0];
                res.ovf  = cnt_over;
                mesh_results_q.push_back(res);
                mom_x = '0;
                mom_y = '0;
                mom_z = '0;
                vol_acc = '0;
                tri_cnt = 0;
                cnt_over = 1'b0;
            end
        end
        // result transfer
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (mesh_results_q.size() == 0) begin
                report_mismatch("unexpected result", 64'(i_six_volume), 64'd0);
            end else begin
                res = mesh_results_q.pop_front();
                if (i_center_x !== res.cx) report_mismatch("center_x", 64'(i_center_x), 64'(res.cx));
                if (i_center_y !== res.cy) report_mismatch("center_y", 64'(i_center_y), 64'(res.cy));
                if (i_center_z !== res.cz) report_mismatch("center_z", 64'(i_center_z), 64'(res.cz));
                if (i_six_volume !== res.sixv)
                    report_mismatch("six_volume", 64'(i_six_volume), 64'(res.sixv));
                if (i_degenerate !== res.degen)
                    report_mismatch("degenerate", 64'(i_degenerate), 64'(res.degen));
                if (i_overflow !== res.ovf)
                    report_mismatch("overflow", 64'(i_overflow), 64'(res.ovf));
            end
        end
        o_backlog = mesh_results_q.size();
    end

    final begin
    end
endmodule

// ===== tb/mesh_center_of_mass_unit_tb.sv =====
// testbench top for the mesh center of mass unit: stimulus, stalls and verdict
module mesh_center_of_mass_unit_tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [11:0] ax = '0, ay = '0, az = '0, bx = '0, by_c = '0, bz = '0;
    logic [11:0] cx = '0, cy = '0, cz = '0;
    logic        last_tri = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [19:0] center_x, center_y, center_z;
    logic [62:0] six_volume;
    logic        degenerate, overflow;
    int          failures, backlog;
    int          cycles = 0;
    int          stall_left = 0;
    logic        calm = 1'b0;

    localparam int CYCLE_LIMIT = 3000000;

    always #6 i_clk = ~i_clk;

    mesh_center_of_mass_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_ax(ax), .i_ay(ay), .i_az(az), .i_bx(bx), .i_by_coord(by_c), .i_bz(bz),
        .i_cx(cx), .i_cy(cy), .i_cz(cz), .i_last_triangle(last_tri),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_center_x(center_x), .o_center_y(center_y), .o_center_z(center_z),
        .o_six_volume(six_volume), .o_degenerate(degenerate), .o_overflow(overflow)
    );

    mesh_center_of_mass_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_ax(ax), .i_ay(ay), .i_az(az), .i_bx(bx), .i_by_coord(by_c), .i_bz(bz),
        .i_cx(cx), .i_cy(cy), .i_cz(cz), .i_last_triangle(last_tri),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_center_x(center_x), .i_center_y(center_y), .i_center_z(center_z),
        .i_six_volume(six_volume), .i_degenerate(degenerate), .i_overflow(overflow),
        .o_failures(failures), .o_backlog(backlog)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side stall: the wait for the next result is drawn at each result transfer
    always @(posedge i_clk) begin
        int draw;
        if (out_valid && !out_stall) begin
            draw = calm ? 0 : $urandom_range(0, 15);
            stall_left <= draw;
            out_stall  <= (draw != 0);
        end else if (out_valid && stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    function automatic logic [11:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 12'h800;
            1: return 12'h7ff;
            2: return 12'h000;
            3: return 12'hfff;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [107:0] rand_tri();
        logic [107:0] t;
        for (int k = 0; k < 9; k++) t[k*12 +: 12] = rand_coord();
        return t;
    endfunction

    // one triangle transfer; t packs a, b, c with ax in the low 12 bits
    task automatic send_tri(input logic [107:0] t, input logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        {cz, cy, cx, bz, by_c, bx, az, ay, ax} <= t;
        last_tri <= last;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic send_mesh(input int n);
        for (int k = 0; k < n; k++) send_tri(rand_tri(), k == n - 1);
    endtask

    initial begin
        logic [107:0] t;
        int           len;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, zero volume, cancelling pairs
        send_tri({9{12'h800}}, 1'b1);
        send_tri({9{12'h7ff}}, 1'b1);
        send_tri('0, 1'b1);
        send_tri({12'h7ff, 12'h000, 12'h000, 12'h000, 12'h7ff, 12'h000,
                  12'h000, 12'h000, 12'h7ff}, 1'b1);
        send_tri({12'h800, 12'h000, 12'h000, 12'h000, 12'h800, 12'h000,
                  12'h000, 12'h000, 12'h800}, 1'b1);
        send_tri({12'h800, 12'h7ff, 12'h800, 12'h7ff, 12'h800, 12'h7ff,
                  12'h800, 12'h7ff, 12'h7ff}, 1'b1);
        t = rand_tri();
        send_tri(t, 1'b0);
        send_tri({t[107:72], t[35:0], t[71:36]}, 1'b1);
        t = {12'h7ff, 12'h000, 12'h000, 12'h000, 12'h7ff, 12'h000,
             12'h000, 12'h000, 12'h7ff};
        send_tri(t, 1'b0);
        send_tri({t[107:72], t[35:0], t[71:37], 1'b0}, 1'b1);
        send_tri({12'h001, 12'h002, 12'h003, 12'hffd, 12'h005, 12'h006,
                  12'h007, 12'hff8, 12'h009}, 1'b0);
        send_mesh(3);

        // random meshes, some built from near-cancelling pairs
        for (int items = 0; items < 1880; ) begin
            calm = ($urandom_range(0, 7) == 0);
            if ($urandom_range(0, 3) == 0) begin
                t = rand_tri();
                send_tri(t, 1'b0);
                t = {t[107:72], t[35:0], t[71:36]};
                t[$urandom_range(0, 107)] ^= 1'b1;
                send_tri(t, 1'b1);
                items += 2;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                send_mesh(len);
                items += len;
            end
        end

        calm = 1'b0;
        send_mesh(2);
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (backlog != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
